[sv/npcs_pkg.sv]
package npcs_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int LAST_ENTRY      = PALETTE_ENTRIES - 1;

    localparam int DIST_W          = 25;
    localparam int SUM_W           = 18;
    localparam logic [DIST_W-1:0] DIST_INIT = 25'h1000000;

    localparam logic [0:0] KIND_WRITE = 1'b0;
    localparam logic [0:0] KIND_QUERY = 1'b1;

    // 5-bit level to 8-bit level, rounded to nearest
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [7:0] r;
        case (v)
            5'd0:    r = 8'd0;
            5'd1:    r = 8'd8;
            5'd2:    r = 8'd16;
            5'd3:    r = 8'd25;
            5'd4:    r = 8'd33;
            5'd5:    r = 8'd41;
            5'd6:    r = 8'd49;
            5'd7:    r = 8'd58;
            5'd8:    r = 8'd66;
            5'd9:    r = 8'd74;
            5'd10:   r = 8'd82;
            5'd11:   r = 8'd90;
            5'd12:   r = 8'd99;
            5'd13:   r = 8'd107;
            5'd14:   r = 8'd115;
            5'd15:   r = 8'd123;
            5'd16:   r = 8'd132;
            5'd17:   r = 8'd140;
            5'd18:   r = 8'd148;
            5'd19:   r = 8'd156;
            5'd20:   r = 8'd165;
            5'd21:   r = 8'd173;
            5'd22:   r = 8'd181;
            5'd23:   r = 8'd189;
            5'd24:   r = 8'd197;
            5'd25:   r = 8'd206;
            5'd26:   r = 8'd214;
            5'd27:   r = 8'd222;
            5'd28:   r = 8'd230;
            5'd29:   r = 8'd239;
            5'd30:   r = 8'd247;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

endpackage

[sv/nearest_palette_colour_search.sv]
// Palette write: no result; the block stays ready for the next item.
// Query: the result is set by a scan that reads one palette RAM entry per cycle over
// entries 1 to last and passes each through the read, square and compare stages.
// The result is then registered for output once the output register is free.
// A new item is taken once that result is loaded, even while it waits for transfer.
// aresetn clears control state only; palette contents are undefined until written.
module nearest_palette_colour_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
    // query_red[36:32], query_green[41:37], query_blue[46:42], zero[47]
    input  logic [47:0] s_tdata,
    // kind[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // best_index[7:0], table_address[22:8], zero[23]
    output logic [23:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [npcs_pkg::IDX_W-1:0] LAST_IDX = npcs_pkg::IDX_W'(npcs_pkg::LAST_ENTRY);
    localparam logic [npcs_pkg::IDX_W-1:0] FIRST_IDX = npcs_pkg::IDX_W'(1);

    logic [23:0] palette_mem [npcs_pkg::PALETTE_ENTRIES];

    state_t state_reg, state_next;
    logic   issue_reg;
    logic   v1_reg;
    logic   v2_reg;
    logic   m_tvalid_reg;
    logic [npcs_pkg::IDX_W-1:0] addr_reg;
    logic [npcs_pkg::IDX_W-1:0] idx1_reg;
    logic [npcs_pkg::IDX_W-1:0] idx2_reg;
    logic [npcs_pkg::IDX_W-1:0] best_reg;
    logic [npcs_pkg::DIST_W-1:0] least_sum_reg;
    logic [23:0] rd_data_reg;
    logic [15:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic [7:0]  qr_reg, qg_reg, qb_reg;
    logic [14:0] taddr_reg;
    logic [23:0] m_data_reg;

    logic s_xfer, wr_en, qry_start, scan_end, out_load, better;
    logic [npcs_pkg::SUM_W-1:0] dist_sum;
    logic [4:0] in_qr, in_qg, in_qb;

    assign in_qr = s_tdata[36:32];
    assign in_qg = s_tdata[41:37];
    assign in_qb = s_tdata[46:42];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign wr_en     = s_xfer && (s_tuser == npcs_pkg::KIND_WRITE)
                       && ({1'b0, s_tdata[7:0]} < 9'(npcs_pkg::PALETTE_ENTRIES));
    assign qry_start = s_xfer && (s_tuser == npcs_pkg::KIND_QUERY);
    assign scan_end  = v2_reg && (idx2_reg == LAST_IDX);
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign dist_sum = npcs_pkg::SUM_W'(sq_r_reg) + npcs_pkg::SUM_W'(sq_g_reg)
                    + npcs_pkg::SUM_W'(sq_b_reg);
    assign better   = v2_reg && (npcs_pkg::DIST_W'(dist_sum) < least_sum_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (qry_start) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_end) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // palette RAM: writes only while idle, reads only while scanning
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            palette_mem[s_tdata[npcs_pkg::IDX_W-1:0]] <= {s_tdata[15:8], s_tdata[23:16],
                                                          s_tdata[31:24]};
        end
        if (issue_reg) begin
            rd_data_reg <= palette_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issue_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue_reg;
            v2_reg    <= v1_reg;
            if (qry_start) begin
                issue_reg <= 1'b1;
            end else if (issue_reg && (addr_reg == LAST_IDX)) begin
                issue_reg <= 1'b0;
            end
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            if (out_load) m_tvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (qry_start) begin
            addr_reg      <= FIRST_IDX;
            qr_reg        <= npcs_pkg::widen5(in_qr);
            qg_reg        <= npcs_pkg::widen5(in_qg);
            qb_reg        <= npcs_pkg::widen5(in_qb);
            taddr_reg     <= {in_qr, in_qg, in_qb};
            best_reg      <= FIRST_IDX;
            least_sum_reg <= npcs_pkg::DIST_INIT;
        end else begin
            if (issue_reg) addr_reg <= addr_reg + FIRST_IDX;
            // strict less-than keeps the lowest index on ties
            if (better) begin
                best_reg      <= idx2_reg;
                least_sum_reg <= npcs_pkg::DIST_W'(dist_sum);
            end
        end
        idx1_reg <= addr_reg;
        idx2_reg <= idx1_reg;
        sq_r_reg <= npcs_pkg::sq_diff(rd_data_reg[23:16], qr_reg);
        sq_g_reg <= npcs_pkg::sq_diff(rd_data_reg[15:8], qg_reg);
        sq_b_reg <= npcs_pkg::sq_diff(rd_data_reg[7:0], qb_reg);
        if (out_load) begin
            m_data_reg <= {1'b0, taddr_reg, 8'(best_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[test/nearest_palette_colour_search_test.sv]
module nearest_palette_colour_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_WAIT = 18;

    typedef struct {
        logic [0:0] kind;
        logic [7:0] entry;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] q_red;
        logic [4:0] q_green;
        logic [4:0] q_blue;
    } palette_op_t;

    typedef struct {
        logic [7:0]  best_index;
        logic [14:0] table_address;
    } nearest_match_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = npcs_pkg::KIND_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;

    palette_op_t    pending_ops[$];
    nearest_match_t expected_matches[$];

    // palette as the block should hold it, and the copy used while building stimulus
    logic [23:0] palette_rgb [npcs_pkg::PALETTE_ENTRIES];
    logic [23:0] planned_rgb [npcs_pkg::PALETTE_ENTRIES];

    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic out_shown = 1'b0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b1;

    int items_total = 0;
    int items_taken = 0;
    int n_writes = 0;
    int n_queries = 0;
    int n_results = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    nearest_palette_colour_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic int level8(input logic [4:0] v);
        return (int'(v) * 255 + 15) / 31;
    endfunction

    function automatic logic [7:0] nearest_entry(input logic [4:0] qr, input logic [4:0] qg,
                                                 input logic [4:0] qb);
        int lr, lg, lb, dr, dg, db, sq_sum, least_sum;
        logic [7:0] best;
        lr = level8(qr);
        lg = level8(qg);
        lb = level8(qb);
        best = 8'd1;
        least_sum = int'(npcs_pkg::DIST_INIT);
        for (int i = 1; i < npcs_pkg::PALETTE_ENTRIES; i++) begin
            dr = int'(palette_rgb[i][23:16]) - lr;
            dg = int'(palette_rgb[i][15:8]) - lg;
            db = int'(palette_rgb[i][7:0]) - lb;
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < least_sum) begin
                best = 8'(i);
                least_sum = sq_sum;
                // exact hit, nothing later can win
                if (sq_sum == 0)
                    break;
            end
        end
        return best;
    endfunction

    function automatic int pick_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    task automatic push_write(input int idx, input int r, input int g, input int b);
        palette_op_t op;
        op.kind = npcs_pkg::KIND_WRITE;
        op.entry = 8'(idx);
        op.red = 8'(r);
        op.green = 8'(g);
        op.blue = 8'(b);
        // query fields are don't-care on a write, keep them random
        op.q_red = 5'($urandom_range(0, 31));
        op.q_green = 5'($urandom_range(0, 31));
        op.q_blue = 5'($urandom_range(0, 31));
        if (idx < npcs_pkg::PALETTE_ENTRIES)
            planned_rgb[idx] = {op.red, op.green, op.blue};
        pending_ops.push_back(op);
        items_total++;
    endtask

    task automatic push_query(input int qr, input int qg, input int qb);
        palette_op_t op;
        op.kind = npcs_pkg::KIND_QUERY;
        op.entry = 8'($urandom);
        op.red = 8'($urandom);
        op.green = 8'($urandom);
        op.blue = 8'($urandom);
        op.q_red = 5'(qr);
        op.q_green = 5'(qg);
        op.q_blue = 5'(qb);
        pending_ops.push_back(op);
        items_total++;
    endtask

    task automatic push_random_write();
        push_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
    endtask

    // input side: present the next pending item once the previous one has transferred
    always @(negedge aclk) begin : tx_drive
        palette_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_tvalid || in_fire) begin
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                s_tdata <= {1'b0, op.q_blue, op.q_green, op.q_red,
                            op.blue, op.green, op.red, op.entry};
                s_tuser <= op.kind;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                tx_wait <= pick_wait(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: after each transfer draw a stall, counted once the next result shows
    always @(negedge aclk) begin : rx_drive
        int w;
        if (!aresetn) begin
            m_tready <= 1'b1;
            rx_wait <= 0;
        end else if (out_fire) begin
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            w = pick_wait(rx_calm);
            rx_wait <= w;
            m_tready <= (w == 0);
        end else if (rx_wait > 0 && out_shown) begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end
    end

    always @(posedge aclk) begin : monitor
        nearest_match_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
            out_fire <= 1'b0;
            out_shown <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            out_shown <= m_tvalid;
            if (s_tvalid && s_tready) begin
                items_taken++;
                if (s_tuser == npcs_pkg::KIND_WRITE) begin
                    if (int'(s_tdata[7:0]) < npcs_pkg::PALETTE_ENTRIES)
                        palette_rgb[s_tdata[7:0]] =
                            {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
                    n_writes++;
                end else begin
                    want.best_index = nearest_entry(s_tdata[36:32], s_tdata[41:37],
                                                    s_tdata[46:42]);
                    want.table_address = {s_tdata[36:32], s_tdata[41:37], s_tdata[46:42]};
                    expected_matches.push_back(want);
                    n_queries++;
                end
            end
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_matches.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual index %0d addr %0d",
                             $realtime, m_tdata[7:0], m_tdata[22:8]);
                    n_errors++;
                end else begin
                    want = expected_matches.pop_front();
                    if (m_tdata[7:0] !== want.best_index) begin
                        $display("%0t: best_index expected %0d actual %0d",
                                 $realtime, want.best_index, m_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_tdata[22:8] !== want.table_address) begin
                        $display("%0t: table_address expected %0d actual %0d",
                                 $realtime, want.table_address, m_tdata[22:8]);
                        n_errors++;
                    end
                    if (m_tdata[23] !== 1'b0) begin
                        $display("%0t: pad bit expected 0 actual %b", $realtime, m_tdata[23]);
                        n_errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("nearest_palette_colour_search test failed");
                $finish;
            end
        end
    end

    initial begin
        int pick, qr, qg, qb, idx, src;

        // full palette load first, so no query ever reads an unwritten entry
        for (int i = 0; i < npcs_pkg::PALETTE_ENTRIES; i++)
            push_write(i, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));

        // entry 0 matches exactly but must never be picked
        push_write(0, 0, 0, 0);
        push_query(0, 0, 0);
        push_write(255, 255, 255, 255);
        push_query(31, 31, 31);
        // exact duplicates: lowest index wins and the model's search stops there
        push_write(17, level8(16), level8(8), level8(4));
        push_write(200, level8(16), level8(8), level8(4));
        push_query(16, 8, 4);
        push_write(1, 0, 255, 0);
        push_query(0, 31, 0);
        push_write(2, 255, 0, 0);
        push_write(3, 0, 0, 255);
        push_query(31, 0, 0);
        push_query(0, 0, 31);
        // equal nonzero distance on either side of the query
        push_write(100, level8(10) + 2, level8(10), level8(10));
        push_write(101, level8(10) - 2, level8(10), level8(10));
        push_query(10, 10, 10);
        push_query(31, 0, 31);
        push_query(0, 31, 31);

        while (items_total < 1400) begin
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                push_query($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
            end else if (pick < 68) begin
                qr = $urandom_range(0, 31);
                qg = $urandom_range(0, 31);
                qb = $urandom_range(0, 31);
                push_write($urandom_range(1, 255), level8(qr), level8(qg), level8(qb));
                push_query(qr, qg, qb);
            end else if (pick < 76) begin
                // copy one entry over another to set up ties
                src = $urandom_range(1, 255);
                idx = $urandom_range(1, 255);
                push_write(idx, planned_rgb[src][23:16], planned_rgb[src][15:8],
                           planned_rgb[src][7:0]);
            end else if (pick < 92) begin
                push_random_write();
            end else begin
                push_query($urandom_range(0, 1) * 31, $urandom_range(0, 1) * 31,
                           $urandom_range(0, 1) * 31);
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!(items_taken == items_total && expected_matches.size() == 0))
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Covered %0d palette writes and %0d color queries, %0d results checked.",
                 n_writes, n_queries, n_results);
        $display("Queries included exact hits, ties, entry 0 matches and channel extremes.");
        if (n_errors == 0 && expected_matches.size() == 0) begin
            $display("nearest_palette_colour_search test passed");
        end else begin
            $display("nearest_palette_colour_search test failed");
        end
        $finish;
    end

endmodule
